// ===== hdl/dnr_pkg.sv =====
// ----------------------------------------------------------------------------
// dnr_pkg
// shared types and constants of the DNA5 N-randomizer (MT19937 generator)
// ----------------------------------------------------------------------------
package dnr_pkg;

  // generator geometry
  localparam int MT_N  = 624;
  localparam int MT_M  = 397;
  localparam int MT_W  = 32;
  localparam int IDX_W = 10;

  localparam logic [MT_W-1:0] MT_MATRIX   = 32'h9908_B0DF;
  localparam logic [MT_W-1:0] MT_UPPER    = 32'h8000_0000;
  localparam logic [MT_W-1:0] MT_LOWER    = 32'h7FFF_FFFF;
  localparam logic [MT_W-1:0] MT_INIT_MUL = 32'd1812433253;
  localparam logic [MT_W-1:0] SEED_RESET  = 32'd42;

  // stream payload
  localparam int SYM_W  = 3;
  localparam int BASE_W = 2;
  localparam logic [SYM_W-1:0] SYM_N = 3'd4;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_LSB    = 2;
  localparam logic [CFG_ADDR_W-REG_LSB-1:0] REG_SEED = 1'b0;

  // command to the generator
  typedef struct packed {
    logic            seed_go;
    logic            draw_go;
    logic [MT_W-1:0] seed;
  } dnr_cmd_t;

  // status back from the generator
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [BASE_W-1:0] rnd;
  } dnr_sts_t;

endpackage

// ===== hdl/dnr_sym_if.sv =====
// ----------------------------------------------------------------------------
// dnr_sym_if
// symbol stream channel: valid/ready handshake with DNA5 symbol payload
// ----------------------------------------------------------------------------
interface dnr_sym_if import dnr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             first_of_sequence;

  modport source (output valid, output symbol, output first_of_sequence, input ready);
  modport sink   (input valid, input symbol, input first_of_sequence, output ready);
endinterface

// ===== hdl/dnr_base_if.sv =====
// ----------------------------------------------------------------------------
// dnr_base_if
// result stream channel: valid/ready handshake with resolved base payload
// ----------------------------------------------------------------------------
interface dnr_base_if import dnr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base;
  logic              was_replaced;

  modport source (output valid, output base, output was_replaced, input ready);
  modport sink   (input valid, input base, input was_replaced, output ready);
endinterface

// ===== hdl/dnr_mt_gen.sv =====
// ----------------------------------------------------------------------------
// dnr_mt_gen
// MT19937 state memory with serial seeding and a per-word lazy twist
// ----------------------------------------------------------------------------
module dnr_mt_gen import dnr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dnr_cmd_t cmd,
  output dnr_sts_t sts
);

  typedef enum logic [2:0] {G_IDLE, G_SEED, G_A0, G_A1, G_A2, G_FIN} gen_state_t;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MT_N - 1);
  localparam logic [IDX_W-1:0] IDX_END  = IDX_W'(MT_N);
  localparam logic [IDX_W-1:0] IDX_WRAP = IDX_W'(MT_N - MT_M);
  localparam logic [IDX_W-1:0] IDX_OFS  = IDX_W'(MT_M);

  function automatic logic [MT_W-1:0] temper(input logic [MT_W-1:0] x);
    logic [MT_W-1:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  logic [MT_W-1:0] mem [MT_N];

  gen_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [MT_W-1:0]   seed_lat_r, seed_lat_nxt;
  logic [MT_W-1:0]   prev_r, prev_nxt;
  logic [MT_W-1:0]   w0_r, w0_nxt;
  logic [MT_W-1:0]   w1_r, w1_nxt;
  logic [BASE_W-1:0] rnd_r, rnd_nxt;
  logic              done_r, done_nxt;
  logic [MT_W-1:0]   rdata_r;

  logic [IDX_W-1:0]  idx_p1, idx_pm, raddr;
  logic [MT_W-1:0]   mix, prod, seed_word, y, twist_word, wdata, tempered;
  logic              we;

  // neighbor addresses of the word being twisted
  assign idx_p1 = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
  assign idx_pm = (idx_r >= IDX_WRAP) ? idx_r - IDX_WRAP : idx_r + IDX_OFS;

  // init recurrence: one multiply per word
  assign mix       = prev_r ^ (prev_r >> 30);
  assign prod      = MT_INIT_MUL * mix;
  assign seed_word = (idx_r == '0) ? seed_lat_r : prod + MT_W'(idx_r);

  // twist of one word from w[i], w[i+1], w[i+m]
  assign y          = (w0_r & MT_UPPER) | (w1_r & MT_LOWER);
  assign twist_word = rdata_r ^ (y >> 1) ^ (y[0] ? MT_MATRIX : '0);
  assign tempered   = temper(twist_word);

  assign we    = (state_r == G_SEED) || (state_r == G_FIN);
  assign wdata = (state_r == G_SEED) ? seed_word : twist_word;

  always_comb begin
    case (state_r)
      G_A1:    raddr = idx_p1;
      G_A2:    raddr = idx_pm;
      default: raddr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx_r] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    seed_lat_nxt = seed_lat_r;
    prev_nxt     = prev_r;
    w0_nxt       = w0_r;
    w1_nxt       = w1_r;
    rnd_nxt      = rnd_r;
    done_nxt     = 1'b0;
    case (state_r)
      G_IDLE: begin
        if (cmd.seed_go) begin
          seed_lat_nxt = cmd.seed;
          idx_nxt      = '0;
          state_nxt    = G_SEED;
        end else if (cmd.draw_go) begin
          idx_nxt   = (pos_r == IDX_END) ? '0 : pos_r;
          state_nxt = G_A0;
        end
      end
      G_SEED: begin
        prev_nxt = seed_word;
        if (idx_r == IDX_LAST) begin
          pos_nxt   = IDX_END;
          done_nxt  = 1'b1;
          state_nxt = G_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      G_A0: state_nxt = G_A1;
      G_A1: begin
        w0_nxt    = rdata_r;
        state_nxt = G_A2;
      end
      G_A2: begin
        w1_nxt    = rdata_r;
        state_nxt = G_FIN;
      end
      G_FIN: begin
        rnd_nxt   = tempered[BASE_W-1:0];
        pos_nxt   = idx_r + 1'b1;
        done_nxt  = 1'b1;
        state_nxt = G_IDLE;
      end
      default: state_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= G_SEED;
      idx_r      <= '0;
      pos_r      <= IDX_END;
      seed_lat_r <= SEED_RESET;
      done_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      pos_r      <= pos_nxt;
      seed_lat_r <= seed_lat_nxt;
      done_r     <= done_nxt;
    end
    prev_r <= prev_nxt;
    w0_r   <= w0_nxt;
    w1_r   <= w1_nxt;
    rnd_r  <= rnd_nxt;
  end

  assign sts.busy = (state_r != G_IDLE);
  assign sts.done = done_r;
  assign sts.rnd  = rnd_r;

endmodule

// ===== hdl/dna_n_randomizer_mt19937_top.sv =====
// ----------------------------------------------------------------------------
// dna_n_randomizer_mt19937_top
// replaces each N of a DNA5 stream by a base drawn from an MT19937 generator
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in_if   | sink      | valid/ready          | symbol[2:0], first_of_sequence
//   out_if  | source    | valid/ready          | base[1:0], was_replaced
//   cfg_*   | slave     | apb, pready tied high| seed at byte address 0
//
// - a plain symbol (no sequence start) is accepted and then goes to the
//   output register
// - an N takes three reads through the one read port of the state memory and
//   one write, then the tempered word
// - a sequence start adds the 624-word seeding, which runs one word per
//   cycle through the one init multiplier
// - after reset the same 624-word seeding pass with seed 42 runs before the
//   first beat is taken; config writes are taken during it
// - in_ready stays low while an item is at work; a stalled out_if holds the
//   finished beat while the next item is accepted and worked on
//
module dna_n_randomizer_mt19937_top import dnr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dnr_sym_if.sink               in_if,
  dnr_base_if.source            out_if,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [1:0] {T_IDLE, T_SEED, T_DRAW, T_PUSH} top_state_t;

  top_state_t        state_r, state_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [BASE_W-1:0] res_base_r, res_base_nxt;
  logic              res_rep_r, res_rep_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BASE_W-1:0] out_base_r, out_base_nxt;
  logic              out_rep_r, out_rep_nxt;
  logic [MT_W-1:0]   seed_r;

  dnr_cmd_t cmd;
  dnr_sts_t sts;

  logic in_acc, out_free, cfg_hit, in_is_n, held_is_n;

  // ---------------------------------------------------------------------------
  // configuration: one seed register, used only at the next sequence start
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:REG_LSB] == REG_SEED);
  assign cfg_prdata = cfg_hit ? seed_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      seed_r <= cfg_pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // generator: state memory, seeding and lazy twist
  // ---------------------------------------------------------------------------
  dnr_mt_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  // ready only while nothing is at work, including the generator's own seeding
  assign in_if.ready = (state_r == T_IDLE) && !sts.busy;
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign in_is_n     = (in_if.symbol == SYM_N);
  assign held_is_n   = (sym_r == SYM_N);

  // seed before the symbol when it opens a sequence; draw only for an N
  assign cmd.seed    = seed_r;
  assign cmd.seed_go = in_acc && in_if.first_of_sequence;
  assign cmd.draw_go = (in_acc && !in_if.first_of_sequence && in_is_n) ||
                       ((state_r == T_SEED) && sts.done && held_is_n);

  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    res_base_nxt  = res_base_r;
    res_rep_nxt   = res_rep_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_base_nxt  = out_base_r;
    out_rep_nxt   = out_rep_r;
    case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          sym_nxt = in_if.symbol;
          if (in_if.first_of_sequence) begin
            state_nxt = T_SEED;
          end else if (in_is_n) begin
            state_nxt = T_DRAW;
          end else begin
            // plain base, undefined codes keep their low bits
            res_base_nxt = in_if.symbol[BASE_W-1:0];
            res_rep_nxt  = 1'b0;
            state_nxt    = T_PUSH;
          end
        end
      end
      T_SEED: begin
        if (sts.done) begin
          if (held_is_n) begin
            state_nxt = T_DRAW;
          end else begin
            res_base_nxt = sym_r[BASE_W-1:0];
            res_rep_nxt  = 1'b0;
            state_nxt    = T_PUSH;
          end
        end
      end
      T_DRAW: begin
        if (sts.done) begin
          res_base_nxt = sts.rnd;
          res_rep_nxt  = 1'b1;
          state_nxt    = T_PUSH;
        end
      end
      T_PUSH: begin
        // hand the result to the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_base_nxt  = res_base_r;
          out_rep_nxt   = res_rep_r;
          state_nxt     = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_r      <= sym_nxt;
    res_base_r <= res_base_nxt;
    res_rep_r  <= res_rep_nxt;
    out_base_r <= out_base_nxt;
    out_rep_r  <= out_rep_nxt;
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  assign out_if.valid        = out_valid_r;
  assign out_if.base         = out_base_r;
  assign out_if.was_replaced = out_rep_r;

endmodule

// ===== hdl/dnr_checker.sv =====
// ----------------------------------------------------------------------------
// dnr_checker
// port-level checks of the N-randomizer, bound to the top level
// ----------------------------------------------------------------------------
module dnr_checker import dnr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [SYM_W-1:0]  in_symbol,
  input logic              in_first,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BASE_W-1:0] out_base,
  input logic              out_was_replaced
);

  // seeding pass after reset keeps the input closed
  a_reset_seed: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during reset seeding");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

  // plain symbol, free output: shows up unchanged via result and output regs
  a_plain_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_first && (in_symbol != SYM_N) && !out_valid
    |=> ##1 out_valid && !out_was_replaced && (out_base == $past(in_symbol[BASE_W-1:0], 2)))
    else $error("plain symbol not passed through");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_base) && $stable(out_was_replaced))
    else $error("result beat changed while stalled");

endmodule

bind dna_n_randomizer_mt19937_top dnr_checker u_dnr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .in_symbol        (in_if.symbol),
  .in_first         (in_if.first_of_sequence),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_base         (out_if.base),
  .out_was_replaced (out_if.was_replaced)
);

// ===== dv/dnr_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnr_stream_checker
// watches the symbol and base channels and the seed register port, predicts
// each resolved base with its own mt19937 generator and compares the result
// ----------------------------------------------------------------------------
module dnr_stream_checker import dnr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dnr_sym_if                    sym_ch,
  dnr_base_if                   base_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    pending,
  output int                    beats_checked,
  output int                    bases_drawn,
  output int                    seq_starts,
  output int                    twists
);

  localparam logic [MT_W-1:0] TEMPER_B    = 32'h9D2C_5680;
  localparam logic [MT_W-1:0] TEMPER_C    = 32'hEFC6_0000;
  localparam int              MAX_PRINTED = 40;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              was_replaced;
  } base_beat_t;

  logic [MT_W-1:0] twister [MT_N];
  int unsigned     next_word;
  logic [MT_W-1:0] seed_shadow;
  base_beat_t      expected_bases [$];

  initial begin
    mismatches    = 0;
    pending       = 0;
    beats_checked = 0;
    bases_drawn   = 0;
    seq_starts    = 0;
    twists        = 0;
  end

  // standard 624-word initialization, next draw forces a twist
  function automatic void seed_twister(input logic [MT_W-1:0] s);
    int              k;
    logic [MT_W-1:0] prev;
    twister[0] = s;
    for (k = 1; k < MT_N; k++) begin
      prev       = twister[k-1];
      twister[k] = MT_INIT_MUL * (prev ^ (prev >> 30)) + MT_W'(k);
    end
    next_word = MT_N;
  endfunction

  function automatic void twist_all();
    int              k;
    logic [MT_W-1:0] y;
    logic [MT_W-1:0] v;
    for (k = 0; k < MT_N; k++) begin
      y = (twister[k] & MT_UPPER) | (twister[(k + 1) % MT_N] & MT_LOWER);
      v = twister[(k + MT_M) % MT_N] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ MT_MATRIX;
      end
      twister[k] = v;
    end
    next_word = 0;
    twists++;
  endfunction

  // tempered output modulo 4
  function automatic logic [BASE_W-1:0] draw_base();
    logic [MT_W-1:0] y;
    if (next_word >= MT_N) begin
      twist_all();
    end
    y = twister[next_word];
    next_word++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y[BASE_W-1:0];
  endfunction

  function automatic base_beat_t predict_base(input logic [SYM_W-1:0] sym, input logic first);
    base_beat_t b;
    if (first) begin
      seed_twister(seed_shadow);
      seq_starts++;
    end
    if (sym == SYM_N) begin
      b.base         = draw_base();
      b.was_replaced = 1'b1;
      bases_drawn++;
    end else begin
      // plain and undefined codes pass their low bits, no draw
      b.base         = sym[BASE_W-1:0];
      b.was_replaced = 1'b0;
    end
    return b;
  endfunction

  // printing stops after a while, counting does not
  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    base_beat_t want;
    if (!rst_n) begin
      seed_shadow = SEED_RESET;
      seed_twister(SEED_RESET);
      expected_bases.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:REG_LSB] == REG_SEED) begin
        if (cfg_pwrite) begin
          seed_shadow = cfg_pwdata;
        end else if (cfg_prdata !== seed_shadow) begin
          report_mismatch($sformatf("seed read back %h, expected %h", cfg_prdata, seed_shadow));
        end
      end
      if (sym_ch.valid && sym_ch.ready) begin
        expected_bases.push_back(predict_base(sym_ch.symbol, sym_ch.first_of_sequence));
      end
      if (base_ch.valid && base_ch.ready) begin
        if (expected_bases.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_bases.pop_front();
          beats_checked++;
          if (base_ch.base !== want.base) begin
            report_mismatch($sformatf("beat %0d base %0d, expected %0d",
                                      beats_checked, base_ch.base, want.base));
          end
          if (base_ch.was_replaced !== want.was_replaced) begin
            report_mismatch($sformatf("beat %0d was_replaced %0b, expected %0b",
                                      beats_checked, base_ch.was_replaced, want.was_replaced));
          end
        end
      end
    end
    pending <= expected_bases.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives symbol beats and seed writes into the dna5 n-randomizer under random
// sender gaps and receiver stalls; a checker beside it predicts every base
// ----------------------------------------------------------------------------
module testbench;
  import dnr_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int CYCLE_LIMIT    = 1_000_000;
  // receiver hold-off, long enough for the block to back up into its input
  localparam int LONG_HOLD      = 600;
  // quiet cycles after the last result
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 120;
  // n-heavy sequence long enough to draw past one full generator state
  localparam int LONG_SEQ_ITEMS = 750;
  localparam int LONG_SEQ_PHASE = 2;

  // dna5 codes besides n, and the codes the alphabet leaves undefined
  localparam logic [SYM_W-1:0] SYM_A  = 3'd0;
  localparam logic [SYM_W-1:0] SYM_C  = 3'd1;
  localparam logic [SYM_W-1:0] SYM_G  = 3'd2;
  localparam logic [SYM_W-1:0] SYM_T  = 3'd3;
  localparam logic [SYM_W-1:0] SYM_X5 = 3'd5;
  localparam logic [SYM_W-1:0] SYM_X6 = 3'd6;
  localparam logic [SYM_W-1:0] SYM_X7 = 3'd7;

  localparam logic [CFG_ADDR_W-1:0] SEED_ADDR = CFG_ADDR_W'({REG_SEED, {REG_LSB{1'b0}}});

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  dnr_sym_if  in_if ();
  dnr_base_if out_if ();

  // checker results
  int mismatches;
  int pending;
  int beats_checked;
  int bases_drawn;
  int seq_starts;
  int twists;

  // stimulus bookkeeping
  int cycle_count = 0;
  int burst_left  = 0;
  int items_sent  = 0;
  int seeds_set   = 0;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;

  dna_n_randomizer_mt19937_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  dnr_stream_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .sym_ch        (in_if),
    .base_ch       (out_if),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .mismatches    (mismatches),
    .pending       (pending),
    .beats_checked (beats_checked),
    .bases_drawn   (bases_drawn),
    .seq_starts    (seq_starts),
    .twists        (twists)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding", cycle_count, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // one symbol beat; the sender works in bursts with idle gaps between them.
  // valid stays high across back-to-back beats of a burst
  task automatic put_symbol(input logic [SYM_W-1:0] sym, input logic first);
    int gap;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      gap        = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid             <= 1'b1;
    in_if.symbol            <= sym;
    in_if.first_of_sequence <= first;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    items_sent++;
  endtask

  // n with the given percentage, now and then an undefined code, else a plain base
  function automatic logic [SYM_W-1:0] random_symbol(input int n_pct);
    if ($urandom_range(99) < n_pct) begin
      return SYM_N;
    end
    if ($urandom_range(24) == 0) begin
      return SYM_W'($urandom_range(5, 7));
    end
    return SYM_W'($urandom_range(0, 3));
  endfunction

  // well-formed sequence: start flag on the first beat only
  task automatic send_sequence(input int len, input int n_pct);
    int k;
    put_symbol(random_symbol(n_pct), 1'b1);
    for (k = 1; k < len; k++) begin
      put_symbol(random_symbol(n_pct), 1'b0);
    end
  endtask

  // stop offering and let every outstanding result drain
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb setup then access; the checker compares read data with its shadow
  task automatic cfg_access(input logic write, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= SEED_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_seed(input logic [CFG_DATA_W-1:0] value);
    cfg_access(1'b1, value);
    cfg_access(1'b0, '0);
    seeds_set++;
  endtask

  // receiver: phases of random stall density, some with no stall at all,
  // and one long hold-off once the random part asks for it
  initial begin : receiver
    int phase_len;
    int stall_pct;
    out_if.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      phase_len = $urandom_range(10, 200);
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      while (phase_len > 0 && !(hold_off_req && !hold_off_done)) begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
        phase_len--;
      end
      if (hold_off_req && !hold_off_done) begin
        // sender keeps offering while results back up
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_done = 1'b1;
      end
    end
  end

  initial begin : stimulus
    int                    phase;
    int                    seq_len;
    int                    n_pct;
    int                    phase_items;
    logic [CFG_DATA_W-1:0] seed;

    rst_n                   = 1'b0;
    cfg_psel                = 1'b0;
    cfg_penable             = 1'b0;
    cfg_pwrite              = 1'b0;
    cfg_paddr               = '0;
    cfg_pwdata              = '0;
    in_if.valid             = 1'b0;
    in_if.symbol            = '0;
    in_if.first_of_sequence = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset value of the seed register, read during the seeding pass
    cfg_access(1'b0, '0);

    // ---- directed part ----
    // symbols ahead of any sequence start use the generator seeded at reset
    put_symbol(SYM_N, 1'b0);
    put_symbol(SYM_N, 1'b0);
    put_symbol(SYM_A, 1'b0);
    put_symbol(SYM_C, 1'b0);
    put_symbol(SYM_G, 1'b0);
    put_symbol(SYM_T, 1'b0);
    // undefined codes pass their low bits and draw nothing
    put_symbol(SYM_X5, 1'b0);
    put_symbol(SYM_X6, 1'b0);
    put_symbol(SYM_X7, 1'b0);
    // re-seed with the default seed, draws interleaved with plain bases
    put_symbol(SYM_N, 1'b1);
    put_symbol(SYM_N, 1'b0);
    put_symbol(SYM_A, 1'b0);
    put_symbol(SYM_N, 1'b0);
    // sequence start on a plain base and on an undefined code: re-seed, no draw
    put_symbol(SYM_A, 1'b1);
    put_symbol(SYM_N, 1'b0);
    put_symbol(SYM_X7, 1'b1);
    put_symbol(SYM_N, 1'b0);
    // back-to-back sequence starts
    put_symbol(SYM_N, 1'b1);
    put_symbol(SYM_N, 1'b1);

    // seed extremes
    wait_idle();
    set_seed('1);
    put_symbol(SYM_N, 1'b1);
    put_symbol(SYM_N, 1'b0);
    put_symbol(SYM_T, 1'b0);
    wait_idle();
    set_seed('0);
    put_symbol(SYM_N, 1'b1);
    put_symbol(SYM_N, 1'b0);

    // ---- random part ----
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       seed = 32'h8000_0000;
        1:       seed = SEED_RESET;
        default: seed = $urandom();
      endcase
      set_seed(seed);
      if (phase == 0) begin
        hold_off_req = 1'b1;
      end

      // the new seed must not apply to the sequence still open from before
      if (phase > 0 && $urandom_range(1) == 1) begin
        repeat ($urandom_range(1, 6)) put_symbol(random_symbol(60), 1'b0);
      end

      if (phase == LONG_SEQ_PHASE) begin
        // draws run past the end of the state, so a second twist follows
        send_sequence(LONG_SEQ_ITEMS, 90);
      end else begin
        phase_items = 0;
        while (phase_items < PHASE_ITEMS) begin
          if ($urandom_range(99) < 85) begin
            seq_len = $urandom_range(1, 30);
            case ($urandom_range(2))
              0:       n_pct = 10;
              1:       n_pct = 50;
              default: n_pct = 90;
            endcase
            send_sequence(seq_len, n_pct);
          end else begin
            // noise: any code, start flags scattered at random
            seq_len = $urandom_range(1, 6);
            repeat (seq_len) put_symbol(SYM_W'($urandom_range(0, 7)), ($urandom_range(3) == 0));
          end
          phase_items += seq_len;
        end
      end
    end

    wait_idle();

    $display("%0d symbol beats sent under %0d seed settings, %0d sequence starts seen",
             items_sent, seeds_set, seq_starts);
    $display("%0d results compared, %0d of them drawn for an N, generator state twisted %0d times",
             beats_checked, bases_drawn, twists);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
